// ===== hdl/ftsu_pkg.sv =====
package ftsu_pkg;

    localparam int SEQ_DEPTH_DEF  = 8192;
    localparam int LOOP_DEPTH_DEF = 67;
    localparam int NUM_INST_DEF   = 20;
    localparam int ROW_WALK_DEF   = 256;

    localparam int CNT_W = 17;   // loop count: high half of param plus one
    localparam int ROW_W = 96;   // op, len, pitch, param

    localparam logic [15:0] ROP_END    = 16'h0046;
    localparam logic [15:0] ROP_VOICE  = 16'h0056;
    localparam logic [15:0] ROP_NOTE   = 16'h0050;
    localparam logic [15:0] ROP_REST   = 16'h0052;
    localparam logic [15:0] ROP_SLIDE  = 16'h0053;
    localparam logic [15:0] ROP_LPOINT = 16'h006C;
    localparam logic [15:0] ROP_LOOP   = 16'h004C;

    typedef enum logic [1:0] {CMD_WR_ROW, CMD_WR_INST, CMD_TICK, CMD_NONE} t_cmd;
    typedef enum logic [1:0] {EV_NONE, EV_NOTE, EV_REST, EV_SLIDE} t_event;
    typedef enum logic [2:0] {
        ERR_NONE, ERR_BAD_ROW, ERR_LOOP_OVF, ERR_TICK_LIMIT, ERR_RUNAWAY
    } t_err;
    typedef enum logic [2:0] {
        RC_END, RC_VOICE, RC_NOTE, RC_REST, RC_SLIDE, RC_LPOINT, RC_LOOP, RC_BAD
    } t_row_class;
    typedef enum logic [3:0] {
        DP_NOP, DP_WR_ROW, DP_WR_INST, DP_TICK_START, DP_SLIDE, DP_ROW_ISSUE,
        DP_ROW_LATCH, DP_EXEC, DP_INST_LATCH, DP_LOOP_ISSUE, DP_LOOP_APPLY,
        DP_WALK_ABORT, DP_VOICE_NEXT, DP_EMIT_NEXT
    } t_dp_op;

    typedef struct packed {
        t_row_class row_class;
        logic       wait_zero;
        logic       halted;
        logic       walk_full;
        logic       last_voice;
    } t_dp_stat;

    function automatic t_row_class classify(input logic [15:0] op);
        t_row_class rc;
        case (op)
            ROP_END:    rc = RC_END;
            ROP_VOICE:  rc = RC_VOICE;
            ROP_NOTE:   rc = RC_NOTE;
            ROP_REST:   rc = RC_REST;
            ROP_SLIDE:  rc = RC_SLIDE;
            ROP_LPOINT: rc = RC_LPOINT;
            ROP_LOOP:   rc = RC_LOOP;
            default:    rc = RC_BAD;
        endcase
        return rc;
    endfunction

endpackage

// ===== hdl/ftsu_in_if.sv =====
interface ftsu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  voice;
    logic [12:0] row_addr;
    logic [15:0] row_op;
    logic [15:0] row_len;
    logic [31:0] row_pitch;
    logic [31:0] row_param;
    logic [4:0]  inst_index;
    logic [20:0] inst_start;
    logic [15:0] inst_len;
    logic [15:0] inst_loop;

    modport source (
        output valid, cmd, voice, row_addr, row_op, row_len, row_pitch, row_param,
               inst_index, inst_start, inst_len, inst_loop,
        input  ready
    );
    modport sink (
        input  valid, cmd, voice, row_addr, row_op, row_len, row_pitch, row_param,
               inst_index, inst_start, inst_len, inst_loop,
        output ready
    );
endinterface

// ===== hdl/ftsu_out_if.sv =====
interface ftsu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_voice;
    logic [1:0]  event_res;
    logic [31:0] pitch;
    logic        sounding;
    logic [20:0] sample_start;
    logic [15:0] sample_len;
    logic [15:0] sample_loop;
    logic [15:0] wait_left;
    logic [3:0]  end_mask;
    logic        song_done;
    logic [2:0]  error;
    logic        last;

    modport source (
        output valid, out_voice, event_res, pitch, sounding, sample_start, sample_len,
               sample_loop, wait_left, end_mask, song_done, error, last,
        input  ready
    );
    modport sink (
        input  valid, out_voice, event_res, pitch, sounding, sample_start, sample_len,
               sample_loop, wait_left, end_mask, song_done, error, last,
        output ready
    );
endinterface

// ===== hdl/four_voice_tick_sequencer_unit.sv =====
// Write transactions (row, instrument) produce no result.
// A tick walks the rows of each processed voice in turn through one shared row
// memory port; a note also reads the instrument table, a loop row the loop stack;
// then four result transactions go out, one per cycle while the sink is ready.
// Synchronous active-low reset clears voice state, end marks, tick count and the
// error; sequence, instrument and loop memories keep their contents, no clear pass.
module four_voice_tick_sequencer_unit #(
    parameter int SEQ_DEPTH       = ftsu_pkg::SEQ_DEPTH_DEF,
    parameter int LOOP_DEPTH      = ftsu_pkg::LOOP_DEPTH_DEF,
    parameter int NUM_INSTRUMENTS = ftsu_pkg::NUM_INST_DEF,
    parameter int ROW_WALK_LIMIT  = ftsu_pkg::ROW_WALK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ftsu_in_if.sink     i_in,
    ftsu_out_if.source  o_out
);
    ftsu_pkg::t_dp_op   dp_op;
    ftsu_pkg::t_dp_stat dp_stat;

    // The controller walks voices and rows; the datapath holds all state and memories.
    ftsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_cmd       (i_in.cmd),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_op        (dp_op)
    );

    // Results are read straight from the voice registers, which hold still while
    // the four result transactions drain.
    ftsu_datapath #(
        .SEQ_DEPTH       (SEQ_DEPTH),
        .LOOP_DEPTH      (LOOP_DEPTH),
        .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
        .ROW_WALK_LIMIT  (ROW_WALK_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (dp_op),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_voice        (i_in.voice),
        .i_row_addr     (i_in.row_addr),
        .i_row_op       (i_in.row_op),
        .i_row_len      (i_in.row_len),
        .i_row_pitch    (i_in.row_pitch),
        .i_row_param    (i_in.row_param),
        .i_inst_index   (i_in.inst_index),
        .i_inst_start   (i_in.inst_start),
        .i_inst_len     (i_in.inst_len),
        .i_inst_loop    (i_in.inst_loop),
        .o_stat         (dp_stat),
        .o_out_voice    (o_out.out_voice),
        .o_event_res    (o_out.event_res),
        .o_pitch        (o_out.pitch),
        .o_sounding     (o_out.sounding),
        .o_sample_start (o_out.sample_start),
        .o_sample_len   (o_out.sample_len),
        .o_sample_loop  (o_out.sample_loop),
        .o_wait_left    (o_out.wait_left),
        .o_end_mask     (o_out.end_mask),
        .o_song_done    (o_out.song_done),
        .o_error        (o_out.error),
        .o_last         (o_out.last)
    );
endmodule

// ===== hdl/ftsu_ram.sv =====
module ftsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== hdl/ftsu_ctrl.sv =====
module ftsu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_cmd,
    input  logic                i_out_ready,
    input  ftsu_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output ftsu_pkg::t_dp_op    o_op
);
    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_SLIDE, S_CHECK, S_READ, S_EXEC, S_INST,
        S_LISSUE, S_LAPPLY, S_VDONE, S_EMIT
    } t_state;

    t_state r_state, n_state;
    ftsu_pkg::t_cmd cmd;

    assign cmd         = ftsu_pkg::t_cmd'(i_cmd);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        n_state = r_state;
        o_op    = ftsu_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (cmd)
                        ftsu_pkg::CMD_WR_ROW:  o_op = ftsu_pkg::DP_WR_ROW;
                        ftsu_pkg::CMD_WR_INST: o_op = ftsu_pkg::DP_WR_INST;
                        ftsu_pkg::CMD_TICK: begin
                            o_op    = ftsu_pkg::DP_TICK_START;
                            n_state = S_TICK;
                        end
                        ftsu_pkg::CMD_NONE:    o_op = ftsu_pkg::DP_NOP;
                    endcase
                end
            end
            S_TICK:  n_state = i_stat.halted ? S_EMIT : S_SLIDE;
            S_SLIDE: begin
                o_op    = ftsu_pkg::DP_SLIDE;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (!i_stat.wait_zero || i_stat.halted) begin
                    n_state = S_VDONE;
                end else if (i_stat.walk_full) begin
                    o_op    = ftsu_pkg::DP_WALK_ABORT;
                    n_state = S_VDONE;
                end else begin
                    o_op    = ftsu_pkg::DP_ROW_ISSUE;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_op    = ftsu_pkg::DP_ROW_LATCH;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_op = ftsu_pkg::DP_EXEC;
                priority if (i_stat.row_class == ftsu_pkg::RC_NOTE) begin
                    n_state = S_INST;
                end else if (i_stat.row_class == ftsu_pkg::RC_LOOP) begin
                    n_state = S_LISSUE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_INST: begin
                o_op    = ftsu_pkg::DP_INST_LATCH;
                n_state = S_CHECK;
            end
            S_LISSUE: begin
                o_op    = ftsu_pkg::DP_LOOP_ISSUE;
                n_state = S_LAPPLY;
            end
            S_LAPPLY: begin
                o_op    = ftsu_pkg::DP_LOOP_APPLY;
                n_state = S_CHECK;
            end
            S_VDONE: begin
                o_op    = ftsu_pkg::DP_VOICE_NEXT;
                n_state = (i_stat.halted || i_stat.last_voice) ? S_EMIT : S_SLIDE;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_op = ftsu_pkg::DP_EMIT_NEXT;
                    if (i_stat.last_voice) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hdl/ftsu_datapath.sv =====
module ftsu_datapath #(
    parameter int SEQ_DEPTH       = ftsu_pkg::SEQ_DEPTH_DEF,
    parameter int LOOP_DEPTH      = ftsu_pkg::LOOP_DEPTH_DEF,
    parameter int NUM_INSTRUMENTS = ftsu_pkg::NUM_INST_DEF,
    parameter int ROW_WALK_LIMIT  = ftsu_pkg::ROW_WALK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ftsu_pkg::t_dp_op   i_op,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic [1:0]         i_voice,
    input  logic [12:0]        i_row_addr,
    input  logic [15:0]        i_row_op,
    input  logic [15:0]        i_row_len,
    input  logic [31:0]        i_row_pitch,
    input  logic [31:0]        i_row_param,
    input  logic [4:0]         i_inst_index,
    input  logic [20:0]        i_inst_start,
    input  logic [15:0]        i_inst_len,
    input  logic [15:0]        i_inst_loop,
    output ftsu_pkg::t_dp_stat o_stat,
    output logic [1:0]         o_out_voice,
    output logic [1:0]         o_event_res,
    output logic [31:0]        o_pitch,
    output logic               o_sounding,
    output logic [20:0]        o_sample_start,
    output logic [15:0]        o_sample_len,
    output logic [15:0]        o_sample_loop,
    output logic [15:0]        o_wait_left,
    output logic [3:0]         o_end_mask,
    output logic               o_song_done,
    output logic [2:0]         o_error,
    output logic               o_last
);
    localparam int SEQ_AW  = $clog2(SEQ_DEPTH);
    localparam int INST_AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
    localparam int LIX_W   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int LVL_W   = $clog2(LOOP_DEPTH + 1);
    localparam int RW_W    = $clog2(ROW_WALK_LIMIT + 1);
    localparam int LOOP_W  = SEQ_AW + ftsu_pkg::CNT_W;
    localparam int CNT_W   = ftsu_pkg::CNT_W;

    // per-voice state, addressed by the current voice index (reset and the event clear at tick start cover all four)
    logic [1:0]          r_vidx;
    logic [RW_W-1:0]     r_rows;
    logic [SEQ_AW-1:0]   r_ptr     [4];
    logic [15:0]         r_wait    [4];
    logic [31:0]         r_pitch   [4];
    logic [31:0]         r_target  [4];
    logic [31:0]         r_step    [4];
    logic [INST_AW-1:0]  r_inst    [4];
    logic                r_inst_ok [4];
    logic [LVL_W-1:0]    r_level   [4];
    logic                r_sound   [4];
    logic [20:0]         r_sstart  [4];
    logic [15:0]         r_slen    [4];
    logic [15:0]         r_sloop   [4];
    ftsu_pkg::t_event    r_ev      [4];
    logic [3:0]          r_end;
    logic [31:0]         r_tick;
    logic [31:0]         r_limit;
    ftsu_pkg::t_err      r_err;

    // fetched row
    logic [15:0] r_rop, r_rlen;
    logic [31:0] r_rpit, r_rpar;

    logic [ftsu_pkg::ROW_W-1:0] row_rdata;
    logic [52:0]                inst_rdata;
    logic [LOOP_W-1:0]          loop_rdata;

    ftsu_pkg::t_row_class rclass;
    logic              halted;
    logic [SEQ_AW-1:0] cur_ptr, ptr_next;
    logic [LVL_W-1:0]  cur_level, level_m1;
    logic [31:0]       n_tick;
    logic              tick_over;
    logic [16:0]       row_addr_x;
    logic              row_wr_ok, inst_wr_ok, lvl_room;

    // slide
    logic signed [33:0] slide_sum, slide_aim;
    logic               slide_hit;

    // loop apply
    logic [SEQ_AW-1:0] lp_row;
    logic [CNT_W-1:0]  lp_cnt, lp_cnt0, lp_cnt1;

    // RAM ports
    logic                        row_we, row_re;
    logic [SEQ_AW+1:0]           row_waddr, row_raddr;
    logic                        inst_we, inst_re;
    logic                        loop_we, loop_re;
    logic [LIX_W+1:0]            loop_waddr, loop_raddr;
    logic [LOOP_W-1:0]           loop_wdata;

    assign rclass    = ftsu_pkg::classify(r_rop);
    assign halted    = (r_err != ftsu_pkg::ERR_NONE);
    assign cur_ptr   = r_ptr[r_vidx];
    assign ptr_next  = (cur_ptr == SEQ_AW'(SEQ_DEPTH - 1)) ? '0 : cur_ptr + 1'b1;
    assign cur_level = r_level[r_vidx];
    assign level_m1  = cur_level - 1'b1;
    assign lvl_room  = (cur_level < LVL_W'(LOOP_DEPTH));
    assign n_tick    = (r_tick == 32'hFFFF_FFFF) ? r_tick : r_tick + 32'd1;
    assign tick_over = (r_limit != 32'd0) && (n_tick > r_limit);

    assign row_addr_x = {4'd0, i_row_addr};
    assign row_wr_ok  = (row_addr_x < 17'(SEQ_DEPTH));
    assign inst_wr_ok = ({1'b0, i_inst_index} < 6'(NUM_INSTRUMENTS));

    assign slide_sum = $signed({2'b00, r_pitch[r_vidx]})
                     + $signed({{2{r_step[r_vidx][31]}}, r_step[r_vidx]});
    assign slide_aim = $signed({2'b00, r_target[r_vidx]});
    assign slide_hit = r_step[r_vidx][31] ? (slide_sum <= slide_aim)
                                          : (slide_sum >= slide_aim);

    assign lp_row  = loop_rdata[CNT_W +: SEQ_AW];
    assign lp_cnt  = loop_rdata[CNT_W-1:0];
    assign lp_cnt0 = (lp_cnt != '0) ? lp_cnt
                   : ((lp_row == '0) && (row_rdata[95:80] == ftsu_pkg::ROP_END))
                     ? CNT_W'(1) : ({1'b0, r_rpar[31:16]} + CNT_W'(1));
    assign lp_cnt1 = lp_cnt0 - 1'b1;

    // row memory: one region of 2^SEQ_AW rows per voice
    assign row_we    = (i_op == ftsu_pkg::DP_WR_ROW) && row_wr_ok;
    assign row_waddr = {i_voice, row_addr_x[SEQ_AW-1:0]};
    assign row_re    = (i_op == ftsu_pkg::DP_ROW_ISSUE) || (i_op == ftsu_pkg::DP_LOOP_ISSUE);
    assign row_raddr = {r_vidx, cur_ptr};

    ftsu_ram #(.WIDTH(ftsu_pkg::ROW_W), .DEPTH(4 << SEQ_AW)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata ({i_row_op, i_row_len, i_row_pitch, i_row_param}),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign inst_we = (i_op == ftsu_pkg::DP_WR_INST) && inst_wr_ok;
    assign inst_re = (i_op == ftsu_pkg::DP_EXEC) && (rclass == ftsu_pkg::RC_NOTE);

    ftsu_ram #(.WIDTH(53), .DEPTH(NUM_INSTRUMENTS)) u_inst_ram (
        .i_clk   (i_clk),
        .i_we    (inst_we),
        .i_waddr (i_inst_index[INST_AW-1:0]),
        .i_wdata ({i_inst_start, i_inst_len, i_inst_loop}),
        .i_re    (inst_re),
        .i_raddr (r_inst[r_vidx]),
        .o_rdata (inst_rdata)
    );

    // loop stack: push on loop point, seed an empty stack with row 0, write back count
    always_comb begin
        loop_we    = 1'b0;
        loop_waddr = {r_vidx, cur_level[LIX_W-1:0]};
        loop_wdata = {ptr_next, CNT_W'(0)};
        if (i_op == ftsu_pkg::DP_EXEC && rclass == ftsu_pkg::RC_LPOINT && lvl_room) begin
            loop_we    = 1'b1;
            loop_wdata = {cur_ptr, CNT_W'(0)};
        end else if (i_op == ftsu_pkg::DP_EXEC && rclass == ftsu_pkg::RC_LOOP
                     && cur_level == '0) begin
            loop_we    = 1'b1;
            loop_waddr = {r_vidx, LIX_W'(0)};
            loop_wdata = '0;
        end else if (i_op == ftsu_pkg::DP_LOOP_APPLY) begin
            loop_we    = 1'b1;
            loop_waddr = {r_vidx, level_m1[LIX_W-1:0]};
            loop_wdata = {lp_row, lp_cnt1};
        end
    end
    assign loop_re    = (i_op == ftsu_pkg::DP_LOOP_ISSUE);
    assign loop_raddr = {r_vidx, level_m1[LIX_W-1:0]};

    ftsu_ram #(.WIDTH(LOOP_W), .DEPTH(4 << LIX_W)) u_loop_ram (
        .i_clk   (i_clk),
        .i_we    (loop_we),
        .i_waddr (loop_waddr),
        .i_wdata (loop_wdata),
        .i_re    (loop_re),
        .i_raddr (loop_raddr),
        .o_rdata (loop_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_op == ftsu_pkg::DP_ROW_LATCH) begin
            r_rop  <= row_rdata[95:80];
            r_rlen <= row_rdata[79:64];
            r_rpit <= row_rdata[63:32];
            r_rpar <= row_rdata[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vidx  <= '0;
            r_rows  <= '0;
            r_end   <= '0;
            r_tick  <= '0;
            r_limit <= '0;
            r_err   <= ftsu_pkg::ERR_NONE;
            for (int k = 0; k < 4; k++) begin
                r_ptr[k]     <= '0;
                r_wait[k]    <= '0;
                r_pitch[k]   <= '0;
                r_target[k]  <= '0;
                r_step[k]    <= '0;
                r_inst[k]    <= '0;
                r_inst_ok[k] <= 1'b1;
                r_level[k]   <= '0;
                r_sound[k]   <= 1'b0;
                r_sstart[k]  <= '0;
                r_slen[k]    <= '0;
                r_sloop[k]   <= '0;
                r_ev[k]      <= ftsu_pkg::EV_NONE;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            unique case (i_op)
                ftsu_pkg::DP_TICK_START: begin
                    r_vidx <= '0;
                    r_rows <= '0;
                    for (int k = 0; k < 4; k++) begin
                        r_ev[k] <= ftsu_pkg::EV_NONE;
                    end
                    if (!halted) begin
                        r_tick <= n_tick;
                        if (tick_over) begin
                            r_err <= ftsu_pkg::ERR_TICK_LIMIT;
                        end
                    end
                end
                ftsu_pkg::DP_SLIDE: begin
                    if (r_step[r_vidx] != '0) begin
                        if (slide_hit) begin
                            r_pitch[r_vidx] <= r_target[r_vidx];
                            r_step[r_vidx]  <= '0;
                        end else begin
                            r_pitch[r_vidx] <= slide_sum[31:0];
                        end
                    end
                    if (r_wait[r_vidx] != '0) begin
                        r_wait[r_vidx] <= r_wait[r_vidx] - 16'd1;
                    end
                end
                ftsu_pkg::DP_ROW_ISSUE: r_rows <= r_rows + 1'b1;
                ftsu_pkg::DP_ROW_LATCH: r_ptr[r_vidx] <= ptr_next;
                ftsu_pkg::DP_EXEC: begin
                    unique case (rclass)
                        ftsu_pkg::RC_END: begin
                            r_ptr[r_vidx]   <= '0;
                            r_end[r_vidx]   <= 1'b1;
                            r_level[r_vidx] <= '0;
                        end
                        ftsu_pkg::RC_VOICE: begin
                            r_inst[r_vidx]    <= r_rpar[2 +: INST_AW];
                            r_inst_ok[r_vidx] <= (r_rpar[31:2] < 30'(NUM_INSTRUMENTS));
                        end
                        ftsu_pkg::RC_NOTE: begin
                            r_pitch[r_vidx]  <= r_rpit;
                            r_target[r_vidx] <= r_rpit;
                            r_step[r_vidx]   <= '0;
                            r_wait[r_vidx]   <= r_rlen;
                            r_sound[r_vidx]  <= 1'b1;
                            r_ev[r_vidx]     <= ftsu_pkg::EV_NOTE;
                        end
                        ftsu_pkg::RC_REST: begin
                            r_sound[r_vidx] <= 1'b0;
                            r_wait[r_vidx]  <= r_rlen;
                            r_ev[r_vidx]    <= ftsu_pkg::EV_REST;
                        end
                        ftsu_pkg::RC_SLIDE: begin
                            r_target[r_vidx] <= r_rpit;
                            r_wait[r_vidx]   <= r_rlen;
                            r_step[r_vidx]   <= r_rpar;
                            r_ev[r_vidx]     <= ftsu_pkg::EV_SLIDE;
                        end
                        ftsu_pkg::RC_LPOINT: begin
                            if (lvl_room) begin
                                r_level[r_vidx] <= cur_level + 1'b1;
                            end else begin
                                r_err <= ftsu_pkg::ERR_LOOP_OVF;
                            end
                        end
                        ftsu_pkg::RC_LOOP: begin
                            if (cur_level == '0) begin
                                r_level[r_vidx] <= LVL_W'(1);
                            end
                        end
                        ftsu_pkg::RC_BAD: r_err <= ftsu_pkg::ERR_BAD_ROW;
                    endcase
                end
                ftsu_pkg::DP_INST_LATCH: begin
                    if (r_inst_ok[r_vidx]) begin
                        r_sstart[r_vidx] <= inst_rdata[52:32];
                        r_slen[r_vidx]   <= inst_rdata[31:16];
                        r_sloop[r_vidx]  <= inst_rdata[15:0];
                    end else begin
                        r_sstart[r_vidx] <= '0;
                        r_slen[r_vidx]   <= '0;
                        r_sloop[r_vidx]  <= '0;
                    end
                end
                ftsu_pkg::DP_LOOP_APPLY: begin
                    if (lp_cnt1 != '0) begin
                        r_ptr[r_vidx] <= lp_row;
                    end else begin
                        r_level[r_vidx] <= level_m1;
                    end
                end
                ftsu_pkg::DP_WALK_ABORT: r_err <= ftsu_pkg::ERR_RUNAWAY;
                ftsu_pkg::DP_VOICE_NEXT: begin
                    r_rows <= '0;
                    r_vidx <= (halted || r_vidx == 2'd3) ? 2'd0 : r_vidx + 2'd1;
                end
                ftsu_pkg::DP_EMIT_NEXT: r_vidx <= r_vidx + 2'd1;
                ftsu_pkg::DP_NOP, ftsu_pkg::DP_WR_ROW, ftsu_pkg::DP_WR_INST,
                ftsu_pkg::DP_LOOP_ISSUE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.row_class  = rclass;
    assign o_stat.wait_zero  = (r_wait[r_vidx] == '0);
    assign o_stat.halted     = halted;
    assign o_stat.walk_full  = (r_rows >= RW_W'(ROW_WALK_LIMIT));
    assign o_stat.last_voice = (r_vidx == 2'd3);

    assign o_out_voice    = r_vidx;
    assign o_event_res    = r_ev[r_vidx];
    assign o_pitch        = r_pitch[r_vidx];
    assign o_sounding     = r_sound[r_vidx];
    assign o_sample_start = r_sstart[r_vidx];
    assign o_sample_len   = r_slen[r_vidx];
    assign o_sample_loop  = r_sloop[r_vidx];
    assign o_wait_left    = r_wait[r_vidx];
    assign o_end_mask     = r_end;
    assign o_song_done    = &r_end;
    assign o_error        = r_err;
    assign o_last         = (r_vidx == 2'd3);
endmodule

// ===== tb/four_voice_tick_sequencer_unit_tb.sv =====
module four_voice_tick_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftsu_pkg::*;

    // One input transaction, all fields; unused ones carry random values.
    typedef struct {
        t_cmd        cmd;
        logic [1:0]  voice;
        logic [12:0] addr;
        logic [15:0] op;
        logic [15:0] len;
        logic [31:0] pitch;
        logic [31:0] param;
        logic [4:0]  iidx;
        logic [20:0] istart;
        logic [15:0] ilen;
        logic [15:0] iloop;
    } t_seq_item;

    // What one voice reports at the end of a tick.
    typedef struct packed {
        logic [1:0]  voice;
        t_event      ev;
        logic [31:0] pitch;
        logic        sounding;
        logic [20:0] start;
        logic [15:0] length;
        logic [15:0] loop_len;
        logic [15:0] wait_left;
        logic [3:0]  end_mask;
        logic        done;
        t_err        err;
        logic        last;
    } t_voice_report;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;

    ftsu_in_if  in_if();
    ftsu_out_if out_if();

    four_voice_tick_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow of the sequencer: memories, per-voice playback state, flags.
    // ------------------------------------------------------------------
    logic [15:0] seq_op    [4][SEQ_DEPTH_DEF];
    logic [15:0] seq_len   [4][SEQ_DEPTH_DEF];
    logic [31:0] seq_pitch [4][SEQ_DEPTH_DEF];
    logic [31:0] seq_param [4][SEQ_DEPTH_DEF];
    logic [20:0] inst_start_tab [NUM_INST_DEF];
    logic [15:0] inst_len_tab   [NUM_INST_DEF];
    logic [15:0] inst_loop_tab  [NUM_INST_DEF];

    logic [12:0] rd_ptr   [4];
    logic [15:0] wait_cnt [4];
    logic [31:0] cur_pitch[4];
    logic [31:0] slide_tgt[4];
    logic [31:0] slide_stp[4];
    int unsigned instr    [4];
    int unsigned loop_lvl [4];
    logic [12:0] loop_ret [4][LOOP_DEPTH_DEF];
    int unsigned loop_rem [4][LOOP_DEPTH_DEF];
    logic        lat_snd  [4];
    logic [20:0] lat_start[4];
    logic [15:0] lat_len  [4];
    logic [15:0] lat_loop [4];
    logic [3:0]  end_bits;
    logic [31:0] tick_cnt;
    logic [31:0] tick_limit_reg;
    t_err        halt;

    t_voice_report expected_voices[$];
    int song_len[4];
    int mismatches;
    bit no_idle;

    // Move pitch one step toward the slide target; clamp and stop on reach.
    function automatic void advance_slide(int k);
        longint st;
        longint sum;
        if (slide_stp[k] == 0) return;
        st  = longint'($signed(slide_stp[k]));
        sum = longint'(cur_pitch[k]) + st;
        if ((st > 0 && sum >= longint'(slide_tgt[k])) ||
            (st < 0 && sum <= longint'(slide_tgt[k]))) begin
            cur_pitch[k] = slide_tgt[k];
            slide_stp[k] = '0;
        end else begin
            cur_pitch[k] = sum[31:0];
        end
    endfunction

    // Run one voice for one tick; walk rows while its wait is zero.
    function automatic t_event walk_voice_rows(int k);
        t_event      ev;
        int          rows;
        logic [12:0] p;
        logic [15:0] op;
        logic [15:0] ln;
        logic [31:0] pt;
        logic [31:0] pr;
        int unsigned lv;
        ev   = EV_NONE;
        rows = 0;
        p    = rd_ptr[k];
        advance_slide(k);
        if (wait_cnt[k] != 0) wait_cnt[k]--;
        while (wait_cnt[k] == 0 && halt == ERR_NONE) begin
            if (rows >= ROW_WALK_DEF) begin
                halt = ERR_RUNAWAY;
                break;
            end
            rows++;
            op = seq_op[k][p];
            ln = seq_len[k][p];
            pt = seq_pitch[k][p];
            pr = seq_param[k][p];
            p  = p + 13'd1;
            case (op)
                ROP_END: begin
                    p = '0;
                    end_bits[k] = 1'b1;
                    loop_lvl[k] = 0;
                end
                ROP_VOICE: instr[k] = pr >> 2;
                ROP_NOTE: begin
                    cur_pitch[k] = pt;
                    slide_tgt[k] = pt;
                    slide_stp[k] = '0;
                    wait_cnt[k]  = ln;
                    if (instr[k] < NUM_INST_DEF) begin
                        lat_start[k] = inst_start_tab[instr[k]];
                        lat_len[k]   = inst_len_tab[instr[k]];
                        lat_loop[k]  = inst_loop_tab[instr[k]];
                    end else begin
                        lat_start[k] = '0;
                        lat_len[k]   = '0;
                        lat_loop[k]  = '0;
                    end
                    lat_snd[k] = 1'b1;
                    ev = EV_NOTE;
                end
                ROP_REST: begin
                    lat_snd[k]  = 1'b0;
                    wait_cnt[k] = ln;
                    ev = EV_REST;
                end
                ROP_SLIDE: begin
                    slide_tgt[k] = pt;
                    wait_cnt[k]  = ln;
                    slide_stp[k] = pr;
                    ev = EV_SLIDE;
                end
                ROP_LPOINT: begin
                    lv = loop_lvl[k];
                    if (lv < LOOP_DEPTH_DEF) begin
                        loop_ret[k][lv] = p;
                        loop_rem[k][lv] = 0;
                        loop_lvl[k] = lv + 1;
                    end else begin
                        halt = ERR_LOOP_OVF;
                    end
                end
                ROP_LOOP: begin
                    // An empty stack loops back to the top of the sequence.
                    if (loop_lvl[k] == 0) begin
                        loop_lvl[k] = 1;
                        loop_ret[k][0] = '0;
                        loop_rem[k][0] = 0;
                    end
                    lv = loop_lvl[k] - 1;
                    if (loop_rem[k][lv] == 0) begin
                        // Looping the whole song right before its end plays it once.
                        if (loop_ret[k][lv] == 0 && seq_op[k][p] == ROP_END)
                            loop_rem[k][lv] = 1;
                        else
                            loop_rem[k][lv] = (pr >> 16) + 1;
                    end
                    loop_rem[k][lv]--;
                    if (loop_rem[k][lv] != 0)
                        p = loop_ret[k][lv];
                    else
                        loop_lvl[k]--;
                end
                default: halt = ERR_BAD_ROW;
            endcase
        end
        rd_ptr[k] = p;
        return ev;
    endfunction

    // Work out the four voice reports of one tick and queue them.
    function automatic void predict_tick();
        t_event        ev[4];
        t_voice_report r;
        for (int k = 0; k < 4; k++) ev[k] = EV_NONE;
        if (halt == ERR_NONE) begin
            if (tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
            if (tick_limit_reg != 0 && tick_cnt > tick_limit_reg) begin
                halt = ERR_TICK_LIMIT;
            end else begin
                for (int k = 0; k < 4; k++)
                    if (halt == ERR_NONE) ev[k] = walk_voice_rows(k);
            end
        end
        for (int k = 0; k < 4; k++) begin
            r.voice     = 2'(k);
            r.ev        = ev[k];
            r.pitch     = cur_pitch[k];
            r.sounding  = lat_snd[k];
            r.start     = lat_start[k];
            r.length    = lat_len[k];
            r.loop_len  = lat_loop[k];
            r.wait_left = wait_cnt[k];
            r.end_mask  = end_bits;
            r.done      = (end_bits == 4'hF);
            r.err       = halt;
            r.last      = (k == 3);
            expected_voices.push_back(r);
        end
    endfunction

    function automatic void apply_item(t_seq_item it);
        case (it.cmd)
            CMD_WR_ROW: begin
                seq_op[it.voice][it.addr]    = it.op;
                seq_len[it.voice][it.addr]   = it.len;
                seq_pitch[it.voice][it.addr] = it.pitch;
                seq_param[it.voice][it.addr] = it.param;
            end
            CMD_WR_INST: begin
                if (it.iidx < NUM_INST_DEF) begin
                    inst_start_tab[it.iidx] = it.istart;
                    inst_len_tab[it.iidx]   = it.ilen;
                    inst_loop_tab[it.iidx]  = it.iloop;
                end
            end
            CMD_TICK: predict_tick();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_seq_item random_item();
        t_seq_item it;
        it.cmd    = t_cmd'($urandom_range(0, 3));
        it.voice  = 2'($urandom);
        it.addr   = 13'($urandom);
        it.op     = 16'($urandom);
        it.len    = 16'($urandom);
        it.pitch  = $urandom;
        it.param  = $urandom;
        it.iidx   = 5'($urandom);
        it.istart = 21'($urandom);
        it.ilen   = 16'($urandom);
        it.iloop  = 16'($urandom_range(0, it.ilen));
        return it;
    endfunction

    function automatic logic [31:0] rand_pitch();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_row_len();
        return ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    endfunction

    function automatic logic [31:0] rand_slide_step();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return $urandom;
            2: return -32'($urandom_range(1, 1000));
            default: return 32'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [31:0] rand_loop_param();
        logic [15:0] cnt;
        cnt = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
        return {cnt, 16'($urandom)};
    endfunction

    // Drive one transaction, hold it until accepted, then update the shadow.
    task automatic send_item(input t_seq_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.cmd        <= it.cmd;
        in_if.voice      <= it.voice;
        in_if.row_addr   <= it.addr;
        in_if.row_op     <= it.op;
        in_if.row_len    <= it.len;
        in_if.row_pitch  <= it.pitch;
        in_if.row_param  <= it.param;
        in_if.inst_index <= it.iidx;
        in_if.inst_start <= it.istart;
        in_if.inst_len   <= it.ilen;
        in_if.inst_loop  <= it.iloop;
        in_if.valid      <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        apply_item(it);
    endtask

    task automatic send_tick();
        t_seq_item it;
        it = random_item();
        it.cmd = CMD_TICK;
        send_item(it);
    endtask

    task automatic write_row(input int v, input int a, input logic [15:0] op,
                             input logic [15:0] ln, input logic [31:0] pt,
                             input logic [31:0] pr);
        t_seq_item it;
        it = random_item();
        it.cmd   = CMD_WR_ROW;
        it.voice = 2'(v);
        it.addr  = 13'(a);
        it.op    = op;
        it.len   = ln;
        it.pitch = pt;
        it.param = pr;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_voices.size() != 0) @(posedge i_clk);
        // Let any write still in flight settle.
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_tick_limit(input logic [31:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tick_limit_reg = val;
        @(posedge i_clk);
    endtask

    // Event row with a random kind; force_wait keeps a loop body from spinning.
    task automatic write_event_row(input int v, inout int a, input bit force_wait);
        logic [15:0] ln;
        ln = force_wait ? 16'($urandom_range(1, 4)) : rand_row_len();
        case (force_wait ? $urandom_range(0, 2) : $urandom_range(0, 3))
            0: write_row(v, a, ROP_NOTE, ln, rand_pitch(), $urandom);
            1: write_row(v, a, ROP_REST, ln, $urandom, $urandom);
            2: write_row(v, a, ROP_SLIDE, ln, rand_pitch(), rand_slide_step());
            default: write_row(v, a, ROP_VOICE, 16'($urandom), $urandom,
                ($urandom_range(0, 3) == 0) ? 32'($urandom)
                    : {30'($urandom_range(0, NUM_INST_DEF - 1)), 2'($urandom)});
        endcase
        a++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_instrument_table();
        t_seq_item it;
        for (int i = 0; i < NUM_INST_DEF + 2; i++) begin
            it = random_item();
            it.cmd  = CMD_WR_INST;
            // Two writes past the table end must leave it untouched.
            it.iidx = (i < NUM_INST_DEF) ? 5'(i) : ((i == NUM_INST_DEF) ? 5'd20 : 5'd31);
            if (i == 0) begin
                it.istart = '0; it.ilen = '0; it.iloop = '0;
            end else if (i == 1) begin
                it.istart = '1; it.ilen = '1; it.iloop = '1;
            end
            send_item(it);
        end
    endtask

    // Every voice opens with a waiting note; voices 0 to 2 add a fixed corner-case prefix, then random rows follow.
    task automatic test_song_load();
        int  a;
        bit  open_l;
        for (int v = 0; v < 4; v++) begin
            a = 0;
            open_l = 0;
            // Row zero always waits so a pass over the song never spins.
            write_row(v, a++, ROP_NOTE, 16'($urandom_range(1, 3)), rand_pitch(), $urandom);
            case (v)
                0: begin
                    write_row(v, a++, ROP_SLIDE, 16'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
                    write_row(v, a++, ROP_VOICE, 16'($urandom), $urandom, 32'hFFFF_FFFF);
                    write_row(v, a++, ROP_NOTE, 16'd0, 32'h0, $urandom);
                    write_row(v, a++, ROP_REST, 16'd1, $urandom, $urandom);
                    write_row(v, a++, ROP_VOICE, 16'($urandom), $urandom, 32'd79);
                    write_row(v, a++, ROP_NOTE, 16'd1, 32'hFFFF_FFFF, $urandom);
                end
                1: begin
                    write_row(v, a++, ROP_SLIDE, 16'd3, 32'h0, 32'h8000_0000);
                    write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                    write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                    write_row(v, a++, ROP_REST, 16'd1, $urandom, $urandom);
                    write_row(v, a++, ROP_LOOP, 16'($urandom), $urandom,
                              {16'd2, 16'($urandom)});
                    write_row(v, a++, ROP_LOOP, 16'($urandom), $urandom,
                              {16'd0, 16'($urandom)});
                end
                2: begin
                    write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                    write_row(v, a++, ROP_SLIDE, 16'd1, rand_pitch(), 32'h0);
                    open_l = 1;
                end
                default: ;
            endcase
            repeat ($urandom_range(4, 8)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: write_event_row(v, a, 0);
                    6, 7, 8: begin
                        bit nest;
                        nest = $urandom_range(0, 2) == 0;
                        write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                        if (nest)
                            write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                        write_event_row(v, a, 1);
                        if ($urandom_range(0, 1)) write_event_row(v, a, 0);
                        if (nest) write_row(v, a++, ROP_LOOP, 16'($urandom), $urandom,
                                            rand_loop_param());
                        write_row(v, a++, ROP_LOOP, 16'($urandom), $urandom,
                                  rand_loop_param());
                    end
                    default: begin
                        write_row(v, a++, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                        open_l = 1;
                    end
                endcase
            end
            // A loop with no open point right before the end covers the whole song.
            if (!open_l && (v == 1 || $urandom_range(0, 1)))
                write_row(v, a++, ROP_LOOP, 16'($urandom), $urandom, rand_loop_param());
            write_row(v, a++, ROP_END, 16'($urandom), $urandom, $urandom);
            song_len[v] = a;
        end
    endtask

    task automatic test_directed_ticks();
        no_idle = 1;
        repeat (12) send_tick();
        no_idle = 0;
    endtask

    // Mostly ticks, mixed with table writes, unused rows and idle commands.
    task automatic test_random_play(input int n, input bit quiet);
        t_seq_item it;
        int r;
        no_idle = quiet;
        repeat (n) begin
            r = $urandom_range(0, 99);
            it = random_item();
            if (r < 55) begin
                it.cmd = CMD_TICK;
            end else if (r < 70) begin
                it.cmd = CMD_WR_INST;
            end else if (r < 90) begin
                it.cmd  = CMD_WR_ROW;
                it.addr = 13'($urandom_range(100, SEQ_DEPTH_DEF - 1));
            end else begin
                it.cmd = CMD_NONE;
            end
            send_item(it);
        end
        no_idle = 0;
    endtask

    // Provoke one kind of halt, then show that it sticks.
    task automatic test_error_halt();
        int kind;
        int v;
        int guard;
        logic [15:0] op;
        t_seq_item it;
        kind = $urandom_range(1, 4);
        v    = $urandom_range(0, 3);
        case (kind)
            1: for (int a = 0; a < song_len[v]; a++) begin
                op = 16'($urandom);
                if ($urandom_range(0, 3) == 0) op = 16'h0;
                while (classify(op) != RC_BAD) op = 16'($urandom);
                write_row(v, a, op, 16'($urandom), $urandom, $urandom);
            end
            2: begin
                for (int a = 0; a < 90; a++)
                    write_row(v, a, ROP_LPOINT, 16'($urandom), $urandom, $urandom);
                write_row(v, 90, ROP_END, 16'($urandom), $urandom, $urandom);
            end
            3: write_tick_limit(tick_cnt);
            default: for (int a = 0; a < song_len[v] - 1; a++)
                write_row(v, a, ROP_VOICE, 16'($urandom), $urandom, $urandom);
        endcase
        guard = 0;
        while (halt == ERR_NONE && guard < 300) begin
            send_tick();
            guard++;
        end
        // Writes are still taken while halted; ticks report the held error.
        repeat (8) begin
            it = random_item();
            if (it.cmd == CMD_WR_ROW) it.addr = 13'($urandom_range(100, SEQ_DEPTH_DEF - 1));
            send_item(it);
        end
        repeat (3) send_tick();
    endtask

    // ------------------------------------------------------------------
    // Result checking and sink-side stalls.
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_voice_report got;
        t_voice_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.voice     = out_if.out_voice;
            got.ev        = t_event'(out_if.event_res);
            got.pitch     = out_if.pitch;
            got.sounding  = out_if.sounding;
            got.start     = out_if.sample_start;
            got.length    = out_if.sample_len;
            got.loop_len  = out_if.sample_loop;
            got.wait_left = out_if.wait_left;
            got.end_mask  = out_if.end_mask;
            got.done      = out_if.song_done;
            got.err       = t_err'(out_if.error);
            got.last      = out_if.last;
            if (expected_voices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected voice result: %p", got);
            end else begin
                want = expected_voices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("voice result mismatch:\n  expected %p\n  actual   %p",
                                 want, got);
                end
            end
        end
        // Stall the result side now and then; hold it off longer on rare occasions.
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        mismatches = 0;
        stall_left = 0;
        no_idle    = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_NONE;
        in_if.voice = '0;
        in_if.row_addr = '0;
        in_if.row_op = '0;
        in_if.row_len = '0;
        in_if.row_pitch = '0;
        in_if.row_param = '0;
        in_if.inst_index = '0;
        in_if.inst_start = '0;
        in_if.inst_len = '0;
        in_if.inst_loop = '0;
        out_if.ready = 1'b1;
        for (int k = 0; k < 4; k++) begin
            rd_ptr[k] = '0; wait_cnt[k] = '0; cur_pitch[k] = '0;
            slide_tgt[k] = '0; slide_stp[k] = '0; instr[k] = 0; loop_lvl[k] = 0;
            lat_snd[k] = 1'b0; lat_start[k] = '0; lat_len[k] = '0; lat_loop[k] = '0;
        end
        end_bits = '0;
        tick_cnt = '0;
        tick_limit_reg = '0;
        halt = ERR_NONE;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_tick_limit(32'hFFFF_FFFF);
        test_instrument_table();
        test_song_load();
        test_directed_ticks();
        test_random_play(60, 0);
        write_tick_limit(32'h0);
        test_random_play(40, 1);
        write_tick_limit($urandom_range(100000, 32'hFFFF_FFFE));
        test_random_play(60, 0);
        test_error_halt();

        in_if.valid <= 1'b0;
        while (expected_voices.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_voices.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
